// ----- rtl/ira_pkg.sv -----
// shared types, constants and helpers for the radix text converter
`default_nettype none

package ira_pkg;

  // converted word width and longest emitted text
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned MAX_CHARS   = 32;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 6;

  // octal gives the most digits
  localparam int unsigned MAX_DIGITS  = (VALUE_BITS + 2) / 3;
  localparam int unsigned DIG_IDX_W   = $clog2(MAX_DIGITS);
  localparam int unsigned DIG_CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int unsigned CHAR_CNT_W  = $clog2(MAX_CHARS + 1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // divide by ten: floor(x * RECIP_TEN / 2^RECIP_SHIFT) is exact for any 32-bit x
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;

  localparam logic [CFG_DATA_W-1:0] FIELD_WIDTH_RESET = 6'd6;

  typedef enum logic [1:0] {
    RADIX_OCT = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2
  } ira_radix_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX  = 2'd0,
    REG_SIGNED = 2'd1,
    REG_WIDTH  = 2'd2
  } ira_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN,
    ST_PAD,
    ST_SIGN,
    ST_DIGIT
  } ira_state_e;

  // one classified word waiting for conversion
  typedef struct packed {
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    ira_radix_e            radix;
    logic                  pad_space;
    logic [CHAR_CNT_W-1:0] width;
  } ira_item_t;

  // lower case hex digit set
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_LOWER_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ira_front.sv -----
// front end: configuration registers, word accept and sign classification
`default_nettype none

module ira_front import ira_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [VALUE_W-1:0]    value_i,
  output logic                       busy_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  full_i,
  output logic                       push_o,
  output ira_item_t                  item_o
);

  ira_radix_e            radix_q;
  logic                  signed_q;
  logic [CFG_DATA_W-1:0] width_q;

  logic [VALUE_BITS-1:0] word;
  logic                  neg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= RADIX_OCT;
      signed_q <= 1'b0;
      width_q  <= FIELD_WIDTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ira_reg_e'(cfg_index_i))
        REG_RADIX:  radix_q  <= ira_radix_e'(cfg_data_i[1:0]);
        REG_SIGNED: signed_q <= cfg_data_i[0];
        REG_WIDTH:  width_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  assign word = value_i[VALUE_BITS-1:0];
  assign neg  = signed_q && word[VALUE_BITS-1];

  always_comb begin
    item_o.mag       = neg ? (~word + VALUE_BITS'(1)) : word;
    item_o.neg       = neg;
    item_o.radix     = radix_q;
    item_o.pad_space = signed_q;
    item_o.width     = (CHAR_CNT_W'(width_q) > CHAR_CNT_W'(MAX_CHARS))
                     ? CHAR_CNT_W'(MAX_CHARS) : CHAR_CNT_W'(width_q);
  end

endmodule

`default_nettype wire

// ----- rtl/ira_queue.sv -----
// short queue between the front end and the converter
`default_nettype none

module ira_queue import ira_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire ira_item_t item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output ira_item_t      item_o
);

  ira_item_t          entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ----- rtl/ira_back.sv -----
// back end: digit generation by repeated division, then character emission
`default_nettype none

module ira_back import ira_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  input  wire ira_item_t          item_i,
  output logic                    pop_o,
  output logic                    char_valid_o,
  output logic [CHAR_W-1:0]       char_code_o,
  output logic                    last_char_o
);

  ira_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] mag_q;
  logic                  neg_q;
  ira_radix_e            radix_q;
  logic                  pad_space_q;
  logic [CHAR_CNT_W-1:0] width_q;
  logic [DIG_CNT_W-1:0]  ndig_q;
  logic [DIG_IDX_W-1:0]  rd_idx_q;
  logic [CHAR_CNT_W-1:0] pad_cnt_q;
  logic [3:0]            digits_q [MAX_DIGITS];

  logic [63:0]           prod;
  logic [VALUE_BITS-1:0] quot_dec;
  logic [VALUE_BITS-1:0] quot;
  logic [3:0]            digit;
  logic                  gen_done;
  logic [CHAR_CNT_W-1:0] text_len;
  logic [CHAR_CNT_W-1:0] pad_len;

  // one digit per cycle, least significant first
  assign prod     = 64'(32'(mag_q)) * 64'(RECIP_TEN);
  assign quot_dec = VALUE_BITS'(prod >> RECIP_SHIFT);

  always_comb begin
    case (radix_q)
      RADIX_OCT: begin
        quot  = mag_q >> 3;
        digit = {1'b0, mag_q[2:0]};
      end
      RADIX_DEC: begin
        quot  = quot_dec;
        digit = 4'(mag_q - ((quot_dec << 3) + (quot_dec << 1)));
      end
      default: begin
        quot  = mag_q >> 4;
        digit = mag_q[3:0];
      end
    endcase
  end

  assign gen_done = (quot == '0);
  assign text_len = CHAR_CNT_W'(ndig_q) + CHAR_CNT_W'(1) + CHAR_CNT_W'(neg_q);
  assign pad_len  = (width_q > text_len) ? (width_q - text_len) : '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = ST_GEN;
        end
      end
      ST_GEN: begin
        if (gen_done) begin
          if (pad_len != '0) begin
            state_d = ST_PAD;
          end else if (neg_q) begin
            state_d = ST_SIGN;
          end else begin
            state_d = ST_DIGIT;
          end
        end
      end
      ST_PAD: begin
        if (pad_cnt_q == CHAR_CNT_W'(1)) begin
          state_d = neg_q ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN:  state_d = ST_DIGIT;
      ST_DIGIT: begin
        if (rd_idx_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o        = 1'b0;
    char_valid_o = 1'b0;
    char_code_o  = CH_ZERO;
    last_char_o  = 1'b0;
    unique case (state_q)
      ST_IDLE:  pop_o = item_valid_i;
      ST_GEN:   ;
      ST_PAD: begin
        char_valid_o = 1'b1;
        char_code_o  = pad_space_q ? CH_SPACE : CH_ZERO;
      end
      ST_SIGN: begin
        char_valid_o = 1'b1;
        char_code_o  = CH_MINUS;
      end
      ST_DIGIT: begin
        char_valid_o = 1'b1;
        char_code_o  = digit_char(digits_q[rd_idx_q]);
        last_char_o  = (rd_idx_q == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          mag_q       <= item_i.mag;
          neg_q       <= item_i.neg;
          radix_q     <= item_i.radix;
          pad_space_q <= item_i.pad_space;
          width_q     <= item_i.width;
          ndig_q      <= '0;
        end
      end
      ST_GEN: begin
        digits_q[ndig_q[DIG_IDX_W-1:0]] <= digit;
        ndig_q <= ndig_q + DIG_CNT_W'(1);
        mag_q  <= quot;
        if (gen_done) begin
          rd_idx_q  <= ndig_q[DIG_IDX_W-1:0];
          pad_cnt_q <= pad_len;
        end
      end
      ST_PAD:   pad_cnt_q <= pad_cnt_q - CHAR_CNT_W'(1);
      ST_DIGIT: begin
        if (rd_idx_q != '0) begin
          rd_idx_q <= rd_idx_q - DIG_IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_digit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GEN |-> ndig_q < DIG_CNT_W'(MAX_DIGITS))
    else $error("digit buffer overrun");
  a_pad_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PAD |-> pad_cnt_q != '0)
    else $error("pad count underflow");
  a_sign_only_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SIGN |-> neg_q)
    else $error("sign emitted for non-negative word");
  a_digit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIGIT |-> DIG_CNT_W'(rd_idx_q) < ndig_q)
    else $error("digit read beyond generated digits");
`endif

endmodule

`default_nettype wire

// ----- rtl/integer_to_radix_ascii.sv -----
// top level: integer to octal, decimal or hexadecimal ascii text
//
// channel   direction  ports                                          transfer at
// word      in         start_i, value_i, busy_o                       start_i & !busy_o
// config    in         cfg_valid_i, cfg_index_i, cfg_data_i, cfg_ready_o  cfg_valid_i & cfg_ready_o
// character out        char_valid_o, char_code_o, last_char_o         every char_valid_o cycle
//
// the front end classifies a word (sign, magnitude, pad style, clipped width) in the
// cycle it is taken and drops it into a two-entry queue; busy_o is high only while
// that queue is full
// the converter takes a word from the queue, generates its digits one per cycle (a
// 32x32 reciprocal multiply for decimal, shifts for octal and hex), then emits one
// character per cycle; a word has 1 to 11 digits, and an unpadded signed 32-bit octal
// word has at most 11 digits and 12 characters
// the receiver cannot stall: each character is shown for exactly one cycle
// reset is asynchronous, active low, clears the queue and the converter and loads
// octal, unsigned, field width 6
`default_nettype none

module integer_to_radix_ascii import ira_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // word input
  input  wire logic                  start_i,
  input  wire logic [VALUE_W-1:0]    value_i,
  output logic                       busy_o,
  // register writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // character output
  output logic                       char_valid_o,
  output logic [CHAR_W-1:0]          char_code_o,
  output logic                       last_char_o
);

  // front to queue
  logic      push;
  ira_item_t push_item;
  logic      queue_full;

  // queue to converter
  logic      pop;
  logic      queue_valid;
  ira_item_t head_item;

  ira_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .full_i      (queue_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  ira_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .item_o  (head_item)
  );

  // converter pulls a word only when it is back in idle
  ira_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_i       (head_item),
    .pop_o        (pop),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

endmodule

`default_nettype wire

// ----- sim/ira_text_checker.sv -----
// checker for the radix text converter: predicts each word's characters and compares them
module ira_text_checker import ira_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_W-1:0]    value_i,
  input  logic                  busy_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  char_valid_i,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic                  last_char_i,
  output int                    fail_count_o,
  output int                    chars_owed_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  text_char_t            owed_chars[$];
  logic [1:0]            radix_code;
  logic                  signed_on;
  logic [CFG_DATA_W-1:0] min_width;
  int                    fails;

  // append the characters one word turns into under the current settings
  function automatic void render_word(input logic [VALUE_W-1:0] word);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  text [0:MAX_CHARS-1];
    logic [CHAR_W-1:0]  pad;
    logic [3:0]         d;
    logic               neg;
    int unsigned        base;
    int unsigned        n;
    int unsigned        span;
    int unsigned        fill;
    int                 i;
    text_char_t         c;
    if (radix_code == RADIX_OCT) begin
      base = 8;
    end else if (radix_code == RADIX_DEC) begin
      base = 10;
    end else begin
      base = 16;
    end
    neg = signed_on && word[VALUE_BITS-1];
    mag = neg ? (~word + 1'b1) : word;
    // digits come out least significant first
    n = 0;
    do begin
      d = 4'(mag % base);
      text[n] = (d > 4'd9) ? CH_LOWER_A + CHAR_W'(d - 4'd10) : CH_ZERO + CHAR_W'(d);
      n = n + 1;
      mag = mag / base;
    end while (mag != 0);
    if (neg) begin
      text[n] = CH_MINUS;
      n = n + 1;
    end
    span = (32'(min_width) > MAX_CHARS) ? MAX_CHARS : 32'(min_width);
    fill = (span > n) ? span - n : 0;
    pad  = signed_on ? CH_SPACE : CH_ZERO;
    for (i = 0; i < int'(fill); i++) begin
      c.code = pad;
      c.last = 1'b0;
      owed_chars.push_back(c);
    end
    for (i = int'(n) - 1; i >= 0; i--) begin
      c.code = text[i];
      c.last = (i == 0);
      owed_chars.push_back(c);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      radix_code = RADIX_OCT;
      signed_on  = 1'b0;
      min_width  = FIELD_WIDTH_RESET;
      owed_chars.delete();
      chars_owed_o <= 0;
    end else begin
      // results first: nothing taken at this edge can already show up here
      if (char_valid_i) begin
        if (owed_chars.size() == 0) begin
          fails = fails + 1;
          $display("%0t: stray char, expected none, got code %h last %b",
                   $time, char_code_i, last_char_i);
        end else begin
          want = owed_chars.pop_front();
          if (char_code_i !== want.code) begin
            fails = fails + 1;
            $display("%0t: char code expected %h got %h", $time, want.code, char_code_i);
          end
          if (last_char_i !== want.last) begin
            fails = fails + 1;
            $display("%0t: last flag expected %b got %b", $time, want.last, last_char_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        render_word(value_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_RADIX:  radix_code = cfg_data_i[1:0];
          REG_SIGNED: signed_on  = cfg_data_i[0];
          REG_WIDTH:  min_width  = cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o <= fails;
      chars_owed_o <= owed_chars.size();
    end
  end

endmodule

// ----- sim/tb_integer_to_radix_ascii.sv -----
// testbench top for the integer to radix ascii converter: stimulus, watchdog and verdict
module tb_integer_to_radix_ascii;
  import ira_pkg::*;

  // index with no register behind it, and the radix code with no name of its own
  localparam logic [CFG_IDX_W-1:0] REG_SPARE        = 2'd3;
  localparam logic [1:0]           RADIX_CODE_THREE = 2'd3;

  localparam int STALL_LIMIT = 2000; // cycles with no transfer on any channel
  localparam int SETTLE      = 16;   // quiet cycles after the last character
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 52;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic [VALUE_W-1:0]    value_i     = '0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  busy_o;
  logic                  cfg_ready_o;
  logic                  char_valid_o;
  logic [CHAR_W-1:0]     char_code_o;
  logic                  last_char_o;

  int fail_count;
  int chars_owed;
  int quiet_cycles = 0;
  bit gaps_on      = 1'b1;

  integer_to_radix_ascii dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .value_i      (value_i),
    .busy_o       (busy_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

  // the checker sits beside the block and sees exactly what the block sees
  ira_text_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .value_i      (value_i),
    .busy_i       (busy_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .char_valid_i (char_valid_o),
    .char_code_i  (char_code_o),
    .last_char_i  (last_char_o),
    .fail_count_o (fail_count),
    .chars_owed_o (chars_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog: any word, register or character transfer resets the count
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || (cfg_valid_i && cfg_ready_o) || char_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // hand one word over; start stays high afterwards so back-to-back words need no drop
  task automatic push_word(input logic [VALUE_W-1:0] v);
    if (gaps_on && $urandom_range(0, 99) < 7) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // one register transfer; the caller lowers valid when the batch is done
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    if (gaps_on && $urandom_range(0, 99) < 7) begin
      cfg_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic load_setting(input logic [CFG_DATA_W-1:0] radix,
                              input logic [CFG_DATA_W-1:0] sgn,
                              input logic [CFG_DATA_W-1:0] width);
    write_reg(REG_RADIX, radix);
    write_reg(REG_SIGNED, sgn);
    write_reg(REG_WIDTH, width);
    cfg_valid_i <= 1'b0;
  endtask

  // stop sending and wait until every predicted character has come out;
  // the extra edge lets the checker log the word taken at the last edge
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (chars_owed != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // random word with a bias toward short texts, sign boundaries and single bits
  function automatic logic [VALUE_W-1:0] pick_word();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = $urandom();
      1:       v = $urandom_range(0, 20);
      2:       v = 32'h8000_0000 + $urandom_range(0, 3);
      3:       v = 32'h7fff_ffff - $urandom_range(0, 3);
      4:       v = -$urandom_range(1, 40);
      default: v = $urandom() >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 9) == 0) begin
      v = 32'd1 << $urandom_range(0, 31);
    end
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    logic [CFG_DATA_W-1:0] w;
    case ($urandom_range(0, 3))
      0:       w = CFG_DATA_W'($urandom_range(0, 6));
      1:       w = CFG_DATA_W'($urandom_range(7, 16));
      2:       w = CFG_DATA_W'($urandom_range(17, 32));
      default: w = CFG_DATA_W'($urandom_range(33, 63));
    endcase
    return w;
  endfunction

  initial begin
    int ph;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: octal, unsigned, field width 6
    push_word(32'd0);
    push_word(32'hffff_ffff);
    push_word(32'd7);
    drain();

    // signed decimal with no padding: most negative, most positive, minus one, zero and five
    load_setting(CFG_DATA_W'(RADIX_DEC), 6'd1, 6'd0);
    push_word(32'h8000_0000);
    push_word(32'h7fff_ffff);
    push_word(32'hffff_ffff);
    push_word(32'd0);
    push_word(32'd5);
    drain();

    // unsigned hex padded to the full text length
    load_setting(CFG_DATA_W'(RADIX_HEX), 6'd0, 6'd32);
    push_word(32'hdead_beef);
    push_word(32'd0);
    drain();

    // a write to the unused index must change nothing; radix code three reads as hex,
    // and a width beyond the longest text saturates
    write_reg(REG_SPARE, 6'h3f);
    load_setting(CFG_DATA_W'(RADIX_CODE_THREE), 6'd1, 6'd63);
    push_word(32'h8000_0000);
    push_word(32'habcd_ef01);
    drain();

    // upper data bits are dropped by the narrow registers: octal, unsigned, width 33
    load_setting(6'h3c, 6'h3e, 6'd33);
    push_word(32'h1234_5678);
    drain();

    // width shorter than the text: nothing is cut
    load_setting(CFG_DATA_W'(RADIX_DEC), 6'd0, 6'd1);
    push_word(32'hffff_ffff);
    push_word(32'd10);
    drain();

    // random phases, each under its own setting; two phases run without gaps
    for (ph = 0; ph < PHASES; ph++) begin
      gaps_on = (ph != 3) && (ph != 4);
      load_setting(CFG_DATA_W'(($urandom_range(0, 15) << 2) | $urandom_range(0, 3)),
                   CFG_DATA_W'($urandom_range(0, 63)), pick_width());
      repeat (PHASE_WORDS) push_word(pick_word());
      drain();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
